[rtl/dmmpd_pkg.sv]
// Shared constants and types for the multimeter packet decoder.
package dmmpd_pkg;

  localparam int PacketLen = 14;
  localparam int FillW     = $clog2(PacketLen + 1);

  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteMinus = 8'h2D;
  localparam logic [7:0] BytePlus  = 8'h2B;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteNine  = 8'h39;
  localparam logic [7:0] ByteColon = 8'h3A;
  localparam logic [7:0] ByteSemi  = 8'h3B;
  localparam logic [7:0] ByteDp1   = 8'h31;
  localparam logic [7:0] ByteDp2   = 8'h32;
  localparam logic [7:0] ByteDp3   = 8'h34;

  typedef enum logic [1:0] {
    DP_NONE = 2'd0,
    DP_1    = 2'd1,
    DP_2    = 2'd2,
    DP_3    = 2'd3
  } dp_t;

  typedef enum logic [3:0] {
    MODE_NONE  = 4'd0,
    MODE_VOLT  = 4'd1,
    MODE_DIODE = 4'd2,
    MODE_AMP   = 4'd3,
    MODE_OHM   = 4'd4,
    MODE_HZ    = 4'd5,
    MODE_FARAD = 4'd6,
    MODE_DUTY  = 4'd7,
    MODE_DEGC  = 4'd8,
    MODE_DEGF  = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    PRE_NONE  = 3'd0,
    PRE_NANO  = 3'd1,
    PRE_MICRO = 3'd2,
    PRE_MILLI = 3'd3,
    PRE_KILO  = 3'd4,
    PRE_MEGA  = 3'd5
  } prefix_t;

  typedef logic [PacketLen-1:0][7:0] packet_t;

  typedef struct packed {
    logic        format_error;
    logic        negative;
    logic        overload;
    logic [15:0] value_bcd;
    dp_t         decimal_pos;
    mode_t       mode;
    prefix_t     prefix;
    logic        hold;
    logic        auto_range;
    logic        show_bar;
    logic        ac_coupled;
  } result_t;

endpackage

[rtl/dmmpd_if.sv]
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface dmmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dmmpd_out_if;
  logic        valid;
  logic        ready;
  logic        format_error;
  logic        negative;
  logic        overload;
  logic [15:0] value_bcd;
  logic [1:0]  decimal_pos;
  logic [3:0]  mode;
  logic [2:0]  prefix;
  logic        hold;
  logic        auto_range;
  logic        show_bar;
  logic        ac_coupled;

  modport source (output valid, output format_error, output negative, output overload,
                  output value_bcd, output decimal_pos, output mode, output prefix,
                  output hold, output auto_range, output show_bar, output ac_coupled,
                  input ready);
  modport sink   (input valid, input format_error, input negative, input overload,
                  input value_bcd, input decimal_pos, input mode, input prefix,
                  input hold, input auto_range, input show_bar, input ac_coupled,
                  output ready);
endinterface

[rtl/dmmpd_decode.sv]
// Combinational decode of one 14-byte packet into a result word.
module dmmpd_decode (
  input  dmmpd_pkg::packet_t pkt,
  output dmmpd_pkg::result_t res
);

  logic            sign_bad;
  logic            ovl_pat;
  logic            digit_bad;
  logic            err;
  logic [15:0]     digits;
  logic [7:0]      b7, b8, b9, b10;
  dmmpd_pkg::dp_t     dp;
  dmmpd_pkg::mode_t   mode;
  dmmpd_pkg::prefix_t pre;
  logic            units;

  assign b7  = pkt[7];
  assign b8  = pkt[8];
  assign b9  = pkt[9];
  assign b10 = pkt[10];

  assign sign_bad = (pkt[0] != dmmpd_pkg::ByteMinus) && (pkt[0] != dmmpd_pkg::BytePlus);
  assign ovl_pat  = (pkt[1] == dmmpd_pkg::ByteSemi) && (pkt[2] == dmmpd_pkg::ByteZero) &&
                    (pkt[3] == dmmpd_pkg::ByteColon) && (pkt[4] == dmmpd_pkg::ByteSemi);

  always_comb begin
    digit_bad = 1'b0;
    digits    = '0;
    for (int i = 1; i <= 4; i++) begin
      if (pkt[i] < dmmpd_pkg::ByteZero || pkt[i] > dmmpd_pkg::ByteNine) begin
        digit_bad = 1'b1;
      end
      digits[(4-i)*4 +: 4] = pkt[i][3:0];
    end
  end

  assign err = sign_bad || (!ovl_pat && digit_bad);

  always_comb begin
    if (pkt[6] == dmmpd_pkg::ByteDp1) begin
      dp = dmmpd_pkg::DP_1;
    end else if (pkt[6] == dmmpd_pkg::ByteDp2) begin
      dp = dmmpd_pkg::DP_2;
    end else if (pkt[6] == dmmpd_pkg::ByteDp3) begin
      dp = dmmpd_pkg::DP_3;
    end else begin
      dp = dmmpd_pkg::DP_NONE;
    end
  end

  always_comb begin
    units = 1'b1;
    if (b10[7]) begin
      mode = b9[2] ? dmmpd_pkg::MODE_DIODE : dmmpd_pkg::MODE_VOLT;
    end else if (b10[6]) begin
      mode = dmmpd_pkg::MODE_AMP;
    end else if (b10[5]) begin
      mode = dmmpd_pkg::MODE_OHM;
    end else if (b10[3]) begin
      mode = dmmpd_pkg::MODE_HZ;
    end else if (b10[2]) begin
      mode = dmmpd_pkg::MODE_FARAD;
    end else if (b9[1]) begin
      mode  = dmmpd_pkg::MODE_DUTY;
      units = 1'b0;
    end else if (b10[1]) begin
      mode  = dmmpd_pkg::MODE_DEGC;
      units = 1'b0;
    end else if (b10[0]) begin
      mode  = dmmpd_pkg::MODE_DEGF;
      units = 1'b0;
    end else begin
      mode = dmmpd_pkg::MODE_NONE;
    end
  end

  always_comb begin
    if (!units) begin
      pre = dmmpd_pkg::PRE_NONE;
    end else if (b8[1]) begin
      pre = dmmpd_pkg::PRE_NANO;
    end else if (b9[7]) begin
      pre = dmmpd_pkg::PRE_MICRO;
    end else if (b9[6]) begin
      pre = dmmpd_pkg::PRE_MILLI;
    end else if (b9[5]) begin
      pre = dmmpd_pkg::PRE_KILO;
    end else if (b9[4]) begin
      pre = dmmpd_pkg::PRE_MEGA;
    end else begin
      pre = dmmpd_pkg::PRE_NONE;
    end
  end

  always_comb begin
    res.format_error = err;
    res.negative     = (pkt[0] == dmmpd_pkg::ByteMinus);
    res.overload     = !err && ovl_pat;
    res.value_bcd    = (err || ovl_pat) ? 16'd0 : digits;
    res.decimal_pos  = err ? dmmpd_pkg::DP_NONE : dp;
    res.mode         = err ? dmmpd_pkg::MODE_NONE : mode;
    res.prefix       = err ? dmmpd_pkg::PRE_NONE : pre;
    res.hold         = b7[1];
    res.auto_range   = b7[5];
    res.show_bar     = b7[0];
    res.ac_coupled   = b7[3];
  end

endmodule

[rtl/dmm_packet_decoder_top.sv]
// Top level: byte window, packet detect, decode and two-entry result buffer.
// The 0x0D word ending a packet registers its result in out_r, or in skid_r on a stall.
// One input word per cycle while skid_r is empty; window shift and decode are combinational.
// A second result register absorbs one result while the output is stalled.
// Reset (synchronous, active low) clears the window, the fill count and both result valids.
module dmm_packet_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  dmmpd_in_if.sink            in_ch,
  dmmpd_out_if.source         out_ch
);

  localparam int LastIdx = dmmpd_pkg::PacketLen - 1;

  dmmpd_pkg::packet_t              win_r, win_nxt;
  logic [dmmpd_pkg::FillW-1:0]     fill_r;
  logic                            accept;
  logic                            hit;
  dmmpd_pkg::result_t              dec_res;
  dmmpd_pkg::result_t              out_r, skid_r;
  logic                            out_valid_r, skid_valid_r;
  logic                            pop;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !skid_valid_r;

  always_comb begin
    for (int i = 0; i < LastIdx; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[LastIdx] = in_ch.rx_byte;
  end

  assign hit = (in_ch.rx_byte == dmmpd_pkg::ByteCr) &&
               (fill_r >= dmmpd_pkg::FillW'(LastIdx));

  dmmpd_decode u_decode (
    .pkt (win_nxt),
    .res (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (accept) begin
      win_r <= win_nxt;
      if (fill_r < dmmpd_pkg::FillW'(dmmpd_pkg::PacketLen)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign pop = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= accept && hit;
        skid_r       <= dec_res;
      end else begin
        out_valid_r <= accept && hit;
        out_r       <= dec_res;
      end
    end else if (accept && hit) begin
      skid_r       <= dec_res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.format_error = out_r.format_error;
  assign out_ch.negative     = out_r.negative;
  assign out_ch.overload     = out_r.overload;
  assign out_ch.value_bcd    = out_r.value_bcd;
  assign out_ch.decimal_pos  = out_r.decimal_pos;
  assign out_ch.mode         = out_r.mode;
  assign out_ch.prefix       = out_r.prefix;
  assign out_ch.hold         = out_r.hold;
  assign out_ch.auto_range   = out_r.auto_range;
  assign out_ch.show_bar     = out_r.show_bar;
  assign out_ch.ac_coupled   = out_r.ac_coupled;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= dmmpd_pkg::FillW'(dmmpd_pkg::PacketLen))
    else $error("fill count past packet length");

  a_rise_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && in_ch.rx_byte == dmmpd_pkg::ByteCr))
    else $error("result without terminating word");

  a_ovl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overload) |-> (!out_r.format_error && out_r.value_bcd == 16'd0))
    else $error("overload result carries error or digits");

endmodule
